FILE: hw/rtl/bsbd_pkg.sv
// Shared types and constants for the bank switching bus decoder.
// Used by bsbd_mem_map, bsbd_io_read and bank_switching_bus_decoder; no dependencies.
package bsbd_pkg;

	typedef enum logic [2:0] {
		CMD_FETCH    = 3'd0,
		CMD_MEM_READ = 3'd1,
		CMD_MEM_WRITE = 3'd2,
		CMD_IO_WRITE = 3'd3,
		CMD_IO_READ  = 3'd4
	} command_t;

	localparam logic [15:0] DISK_ROM_LOW   = 16'h3D00;
	localparam logic [15:0] RAM_BASE       = 16'h4000;
	localparam logic [15:0] BANK_PORT_MASK = 16'h8002;
	localparam logic [13:0] SCREEN_BYTES   = 14'd6912;
	localparam logic [7:0]  KEY_IDLE       = 8'hBF;
	localparam logic [7:0]  JOY_PORT       = 8'h1F;
	localparam logic [7:0]  NO_PORT_DATA   = 8'hFF;
	localparam logic [2:0]  RAM_PAGE_SLOT1 = 3'd5;
	localparam logic [2:0]  RAM_PAGE_SLOT2 = 3'd2;
	localparam logic [2:0]  SCREEN_NORMAL  = 3'd5;
	localparam logic [2:0]  SCREEN_SHADOW  = 3'd7;
	localparam logic [1:0]  ROM_DISK       = 2'd3;

	// Bank register bit positions.
	localparam int BANK_SCREEN_BIT = 3;
	localparam int BANK_ROM_BIT    = 4;
	localparam int BANK_LOCK_BIT   = 5;

	typedef struct packed {
		logic        is_rom;
		logic [2:0]  page;
		logic [13:0] offset;
		logic        write_enable;
		logic        sync;
	} mem_map_t;

	typedef struct packed {
		logic [7:0] data;
		logic       strobe;
		logic [1:0] register;
	} io_read_t;

endpackage

FILE: hw/rtl/bank_switching_bus_decoder.sv
// Top level of the bank switching bus decoder: input register, decode, result register.
// Depends on bsbd_pkg, bsbd_mem_map and bsbd_io_read.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid, in_stall | command, address, write_data, key_rows, tape_level,
//          |                    | disk_read_data, disk_data_request, disk_interrupt
//  out     | out_valid,out_stall| mem_*, io_data, disk_*, border_color, beeper_level,
//          |                    | shadow_screen, video_sync_request
//
// Each request passes through the input register and then the result register on its
// way to the result. A new request is taken every cycle while in_stall is low.
// The banking state updates when a request moves into the result register, so the
// next request already sees it. Reset clears all banking, border and beeper state.
// A stall on the output holds both stages; in_stall rises only when both are full.
module bank_switching_bus_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [63:0] key_rows,
	input  logic        tape_level,
	input  logic [7:0]  disk_read_data,
	input  logic        disk_data_request,
	input  logic        disk_interrupt,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        mem_is_rom,
	output logic [2:0]  mem_page,
	output logic [13:0] mem_offset,
	output logic        mem_write_enable,
	output logic [7:0]  io_data,
	output logic        disk_write_strobe,
	output logic        disk_read_strobe,
	output logic [1:0]  disk_register,
	output logic [2:0]  border_color,
	output logic        beeper_level,
	output logic        shadow_screen,
	output logic        video_sync_request
);

	logic        valid_s1;
	logic [2:0]  command_s1;
	logic [15:0] address_s1;
	logic [7:0]  write_data_s1;
	logic [63:0] key_rows_s1;
	logic        tape_level_s1;
	logic [7:0]  disk_read_data_s1;
	logic        disk_data_request_s1;
	logic        disk_interrupt_s1;

	logic [7:0] bank_q;
	logic       paging_q;
	logic [1:0] rom_q;
	logic [2:0] border_q;
	logic       beeper_q;

	logic [7:0] bank_d;
	logic       paging_d;
	logic [1:0] rom_d;
	logic [2:0] border_d;
	logic       beeper_d;
	logic       io_sync;
	logic       wr_strobe;

	logic out_valid_q;
	logic advance;
	logic in_accept;

	bsbd_pkg::mem_map_t map;
	bsbd_pkg::io_read_t rd;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			command_s1 <= command;
			address_s1 <= address;
			write_data_s1 <= write_data;
			key_rows_s1 <= key_rows;
			tape_level_s1 <= tape_level;
			disk_read_data_s1 <= disk_read_data;
			disk_data_request_s1 <= disk_data_request;
			disk_interrupt_s1 <= disk_interrupt;
		end
	end

	bsbd_mem_map u_mem_map (
		.command    (command_s1),
		.address    (address_s1),
		.bank       (bank_q),
		.rom_select (rom_q),
		.map        (map)
	);

	bsbd_io_read u_io_read (
		.command           (command_s1),
		.address           (address_s1),
		.key_rows          (key_rows_s1),
		.tape_level        (tape_level_s1),
		.disk_read_data    (disk_read_data_s1),
		.disk_data_request (disk_data_request_s1),
		.disk_interrupt    (disk_interrupt_s1),
		.disk_paging       (paging_q),
		.rd                (rd)
	);

	always_comb begin
		bank_d = bank_q;
		paging_d = paging_q;
		rom_d = rom_q;
		border_d = border_q;
		beeper_d = beeper_q;
		io_sync = 1'b0;
		wr_strobe = 1'b0;
		case (command_s1)
			bsbd_pkg::CMD_FETCH: begin
				// Disk ROM paging switches on a fetch from its trap area while ROM 1
				// is selected, and off on any fetch from RAM.
				if (!paging_q && (address_s1 >= bsbd_pkg::DISK_ROM_LOW)
						&& (address_s1 < bsbd_pkg::RAM_BASE)
						&& bank_q[bsbd_pkg::BANK_ROM_BIT]) begin
					paging_d = 1'b1;
					rom_d = bsbd_pkg::ROM_DISK;
				end else if (paging_q && (address_s1 >= bsbd_pkg::RAM_BASE)) begin
					paging_d = 1'b0;
					rom_d = {1'b0, bank_q[bsbd_pkg::BANK_ROM_BIT]};
				end
			end
			bsbd_pkg::CMD_IO_WRITE: begin
				if (((address_s1 & bsbd_pkg::BANK_PORT_MASK) == '0)
						&& !bank_q[bsbd_pkg::BANK_LOCK_BIT]) begin
					if (bank_q[bsbd_pkg::BANK_SCREEN_BIT] != write_data_s1[bsbd_pkg::BANK_SCREEN_BIT])
						io_sync = 1'b1;
					bank_d = write_data_s1;
					rom_d = {1'b0, write_data_s1[bsbd_pkg::BANK_ROM_BIT]};
				end
				if (!address_s1[0]) begin
					io_sync = 1'b1;
					border_d = write_data_s1[2:0];
					beeper_d = write_data_s1[4];
				end
				if (paging_q && (address_s1[1:0] == 2'b11) && !address_s1[7])
					wr_strobe = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
			paging_q <= 1'b0;
			rom_q <= '0;
			border_q <= '0;
			beeper_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				bank_q <= bank_d;
				paging_q <= paging_d;
				rom_q <= rom_d;
				border_q <= border_d;
				beeper_q <= beeper_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mem_is_rom <= map.is_rom;
			mem_page <= map.page;
			mem_offset <= map.offset;
			mem_write_enable <= map.write_enable;
			io_data <= rd.data;
			disk_write_strobe <= wr_strobe;
			disk_read_strobe <= rd.strobe;
			disk_register <= wr_strobe ? address_s1[6:5] : rd.register;
			border_color <= border_d;
			beeper_level <= beeper_d;
			shadow_screen <= bank_d[bsbd_pkg::BANK_SCREEN_BIT];
			video_sync_request <= map.sync || io_sync;
		end
	end

	a_strobes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(disk_write_strobe && disk_read_strobe))
		else $error("disk read and write strobes set together");

	a_no_rom_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(mem_write_enable && mem_is_rom))
		else $error("memory write enabled on ROM");

	a_register_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !disk_write_strobe && !disk_read_strobe) |-> (disk_register == 2'd0))
		else $error("disk register set without a strobe");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(bank_q) && $stable(paging_q) && $stable(rom_q)))
		else $error("banking state changed without a request");

endmodule

FILE: hw/rtl/bsbd_mem_map.sv
// Memory slot translation for the bank switching bus decoder.
// Depends on bsbd_pkg.
module bsbd_mem_map (
	input  logic [2:0]         command,
	input  logic [15:0]        address,
	input  logic [7:0]         bank,
	input  logic [1:0]         rom_select,
	output bsbd_pkg::mem_map_t map
);

	logic [1:0] slot;
	logic [2:0] page;
	logic       is_rom;
	logic [2:0] screen_page;
	logic       is_mem;

	assign slot = address[15:14];
	assign screen_page = bank[bsbd_pkg::BANK_SCREEN_BIT] ?
		bsbd_pkg::SCREEN_SHADOW : bsbd_pkg::SCREEN_NORMAL;
	assign is_mem = command inside {bsbd_pkg::CMD_FETCH, bsbd_pkg::CMD_MEM_READ,
		bsbd_pkg::CMD_MEM_WRITE};

	always_comb begin
		is_rom = 1'b0;
		case (slot)
			2'd0: begin
				is_rom = 1'b1;
				page = {1'b0, rom_select};
			end
			2'd1: page = bsbd_pkg::RAM_PAGE_SLOT1;
			2'd2: page = bsbd_pkg::RAM_PAGE_SLOT2;
			default: page = bank[2:0];
		endcase
	end

	always_comb begin
		map = '0;
		if (is_mem) begin
			map.is_rom = is_rom;
			map.page = page;
			map.offset = address[13:0];
			if (command == bsbd_pkg::CMD_MEM_WRITE) begin
				map.write_enable = !is_rom;
				// Writes into the visible part of the displayed page need the
				// renderer to catch up first.
				map.sync = !is_rom && (page == screen_page)
					&& (address[13:0] < bsbd_pkg::SCREEN_BYTES);
			end
		end
	end

endmodule

FILE: hw/rtl/bsbd_io_read.sv
// IO read port decoding: keyboard and tape, joystick stub, disk controller.
// Depends on bsbd_pkg.
module bsbd_io_read (
	input  logic [2:0]         command,
	input  logic [15:0]        address,
	input  logic [63:0]        key_rows,
	input  logic               tape_level,
	input  logic [7:0]         disk_read_data,
	input  logic               disk_data_request,
	input  logic               disk_interrupt,
	input  logic               disk_paging,
	output bsbd_pkg::io_read_t rd
);

	logic [7:0] keys;

	// Each row whose address line is low pulls its active-low keys into the byte.
	always_comb begin
		keys = bsbd_pkg::KEY_IDLE;
		for (int i = 0; i < 8; i++) begin
			if (!address[8 + i])
				keys = keys & key_rows[8 * i +: 8];
		end
	end

	always_comb begin
		rd = '0;
		rd.data = bsbd_pkg::NO_PORT_DATA;
		if (command == bsbd_pkg::CMD_IO_READ) begin
			if (!address[0])
				rd.data = keys | {1'b0, tape_level, 6'b0};
			if (address[7:0] == bsbd_pkg::JOY_PORT)
				rd.data = '0;
			if (disk_paging && (address[1:0] == 2'b11)) begin
				if (address[7]) begin
					rd.data = {disk_interrupt, disk_data_request, 6'b0};
				end else begin
					rd.data = disk_read_data;
					rd.strobe = 1'b1;
					rd.register = address[6:5];
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb_bank_switching_bus_decoder.sv
// Self-checking testbench for bank_switching_bus_decoder: directed rows, random bus traffic,
// and a closing locked-bank phase, each result compared field by field with a hand-written
// expectation or a built-in decoder. Depends on bsbd_pkg and the bank_switching_bus_decoder RTL.
module tb_bank_switching_bus_decoder;

	localparam int          IDLE_PCT      = 36;
	localparam int          RANDOM_COUNT  = 1250;
	localparam int          DRAIN_LIMIT   = 2000;
	localparam int          SETTLE_CYCLES = 8;
	localparam logic [2:0]  CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [63:0] key_rows;
		logic        tape_level;
		logic [7:0]  disk_read_data;
		logic        disk_data_request;
		logic        disk_interrupt;
	} bus_access_t;

	typedef struct packed {
		logic        mem_is_rom;
		logic [2:0]  mem_page;
		logic [13:0] mem_offset;
		logic        mem_write_enable;
		logic [7:0]  io_data;
		logic        disk_write_strobe;
		logic        disk_read_strobe;
		logic [1:0]  disk_register;
		logic [2:0]  border_color;
		logic        beeper_level;
		logic        shadow_screen;
		logic        video_sync_request;
	} decode_t;

	typedef struct {
		bus_access_t access;
		bit          typed;
		decode_t     want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = bsbd_pkg::CMD_FETCH;
	logic [15:0] address = '0;
	logic [7:0]  write_data = '0;
	logic [63:0] key_rows = '0;
	logic        tape_level = 1'b0;
	logic [7:0]  disk_read_data = '0;
	logic        disk_data_request = 1'b0;
	logic        disk_interrupt = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        mem_is_rom;
	logic [2:0]  mem_page;
	logic [13:0] mem_offset;
	logic        mem_write_enable;
	logic [7:0]  io_data;
	logic        disk_write_strobe;
	logic        disk_read_strobe;
	logic [1:0]  disk_register;
	logic [2:0]  border_color;
	logic        beeper_level;
	logic        shadow_screen;
	logic        video_sync_request;

	// Decoder state mirrored by the testbench.
	logic [7:0] bank_reg;
	logic       disk_paged;
	logic [1:0] rom_sel;
	logic [2:0] border_reg;
	logic       beeper_reg;

	decode_t   expected_decodes[$];
	decode_t   head;
	stim_row_t opening_rows[$];
	stim_row_t locked_rows[$];
	int        mismatch_count = 0;
	bit        steady = 1'b0;

	bank_switching_bus_decoder dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic decode_t decode_access(input bus_access_t acc);
		decode_t    d;
		logic [7:0] keys;
		logic [2:0] shown_page;
		d = '0;
		d.io_data = bsbd_pkg::NO_PORT_DATA;
		shown_page = bank_reg[bsbd_pkg::BANK_SCREEN_BIT] ?
			bsbd_pkg::SCREEN_SHADOW : bsbd_pkg::SCREEN_NORMAL;
		if (acc.command inside {bsbd_pkg::CMD_FETCH, bsbd_pkg::CMD_MEM_READ,
				bsbd_pkg::CMD_MEM_WRITE}) begin
			d.mem_offset = acc.address[13:0];
			case (acc.address[15:14])
				2'd0: begin
					d.mem_is_rom = 1'b1;
					d.mem_page = {1'b0, rom_sel};
				end
				2'd1: d.mem_page = bsbd_pkg::RAM_PAGE_SLOT1;
				2'd2: d.mem_page = bsbd_pkg::RAM_PAGE_SLOT2;
				default: d.mem_page = bank_reg[2:0];
			endcase
			// The translation above uses the map from before any paging switch.
			if (acc.command == bsbd_pkg::CMD_MEM_WRITE) begin
				d.mem_write_enable = acc.address >= bsbd_pkg::RAM_BASE;
				d.video_sync_request = !d.mem_is_rom && d.mem_page == shown_page &&
					d.mem_offset < bsbd_pkg::SCREEN_BYTES;
			end else if (acc.command == bsbd_pkg::CMD_FETCH) begin
				if (!disk_paged && acc.address >= bsbd_pkg::DISK_ROM_LOW &&
						acc.address < bsbd_pkg::RAM_BASE &&
						bank_reg[bsbd_pkg::BANK_ROM_BIT]) begin
					disk_paged = 1'b1;
					rom_sel = bsbd_pkg::ROM_DISK;
				end else if (disk_paged && acc.address >= bsbd_pkg::RAM_BASE) begin
					disk_paged = 1'b0;
					rom_sel = {1'b0, bank_reg[bsbd_pkg::BANK_ROM_BIT]};
				end
			end
		end else if (acc.command == bsbd_pkg::CMD_IO_WRITE) begin
			if ((acc.address & bsbd_pkg::BANK_PORT_MASK) == '0 &&
					!bank_reg[bsbd_pkg::BANK_LOCK_BIT]) begin
				if (bank_reg[bsbd_pkg::BANK_SCREEN_BIT] !=
						acc.write_data[bsbd_pkg::BANK_SCREEN_BIT])
					d.video_sync_request = 1'b1;
				bank_reg = acc.write_data;
				rom_sel = {1'b0, bank_reg[bsbd_pkg::BANK_ROM_BIT]};
			end
			if (!acc.address[0]) begin
				d.video_sync_request = 1'b1;
				border_reg = acc.write_data[2:0];
				beeper_reg = acc.write_data[4];
			end
			if (disk_paged && acc.address[1:0] == 2'b11 && !acc.address[7]) begin
				d.disk_write_strobe = 1'b1;
				d.disk_register = acc.address[6:5];
			end
		end else if (acc.command == bsbd_pkg::CMD_IO_READ) begin
			if (!acc.address[0]) begin
				keys = bsbd_pkg::KEY_IDLE;
				for (int i = 0; i < 8; i++)
					if (!acc.address[8 + i])
						keys &= acc.key_rows[8 * i +: 8];
				d.io_data = keys | {1'b0, acc.tape_level, 6'b0};
			end
			if (acc.address[7:0] == bsbd_pkg::JOY_PORT)
				d.io_data = '0;
			// With disk paging on, port 1F belongs to the disk controller.
			if (disk_paged && acc.address[1:0] == 2'b11) begin
				if (acc.address[7]) begin
					d.io_data = {acc.disk_interrupt, acc.disk_data_request, 6'b0};
				end else begin
					d.io_data = acc.disk_read_data;
					d.disk_read_strobe = 1'b1;
					d.disk_register = acc.address[6:5];
				end
			end
		end
		d.border_color = border_reg;
		d.beeper_level = beeper_reg;
		d.shadow_screen = bank_reg[bsbd_pkg::BANK_SCREEN_BIT];
		return d;
	endfunction

	function automatic stim_row_t access_row(input logic [2:0] cmd, input logic [15:0] addr,
			input logic [7:0] wdata = '0, input logic [63:0] keys = '1,
			input logic tape = 1'b0, input logic [7:0] dread = '0,
			input logic drq = 1'b0, input logic intrq = 1'b0);
		stim_row_t r;
		r.access = '{cmd, addr, wdata, keys, tape, dread, drq, intrq};
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input stim_row_t r, input decode_t want);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic decode_t mem_decode(input logic is_rom, input logic [2:0] page,
			input logic [13:0] offset, input logic wen, input logic sync,
			input logic [2:0] border, input logic beeper, input logic shadow);
		decode_t d;
		d = '0;
		d.mem_is_rom = is_rom;
		d.mem_page = page;
		d.mem_offset = offset;
		d.mem_write_enable = wen;
		d.io_data = bsbd_pkg::NO_PORT_DATA;
		d.border_color = border;
		d.beeper_level = beeper;
		d.shadow_screen = shadow;
		d.video_sync_request = sync;
		return d;
	endfunction

	function automatic decode_t io_decode(input logic [7:0] data, input logic sync,
			input logic [2:0] border, input logic beeper, input logic shadow);
		decode_t d;
		d = mem_decode(1'b0, 3'd0, 14'd0, 1'b0, sync, border, beeper, shadow);
		d.io_data = data;
		return d;
	endfunction

	function automatic bus_access_t random_access();
		bus_access_t acc;
		int unsigned pick;
		pick = $urandom_range(99);
		acc.command = bsbd_pkg::CMD_IO_WRITE;
		acc.address = 16'($urandom);
		acc.write_data = 8'($urandom);
		acc.key_rows = {$urandom, $urandom};
		acc.tape_level = 1'($urandom);
		acc.disk_read_data = 8'($urandom);
		acc.disk_data_request = 1'($urandom);
		acc.disk_interrupt = 1'($urandom);
		if (pick < 12) begin
			acc.command = bsbd_pkg::CMD_FETCH;
			acc.address = bsbd_pkg::DISK_ROM_LOW + 16'($urandom_range(16'h02FF));
		end else if (pick < 22) begin
			acc.command = bsbd_pkg::CMD_FETCH;
		end else if (pick < 32) begin
			acc.command = bsbd_pkg::CMD_MEM_READ;
		end else if (pick < 44) begin
			acc.command = bsbd_pkg::CMD_MEM_WRITE;
		end else if (pick < 54) begin
			acc.address = acc.address & ~bsbd_pkg::BANK_PORT_MASK;
		end else if (pick < 62) begin
			acc.address[0] = 1'b0;
		end else if (pick < 74) begin
			acc.address[1:0] = 2'b11;
		end else if (pick < 94) begin
			acc.command = bsbd_pkg::CMD_IO_READ;
			case ($urandom_range(3))
				0: acc.address[0] = 1'b0;
				1: acc.address[7:0] = bsbd_pkg::JOY_PORT;
				2: acc.address[1:0] = 2'b11;
				default: ;
			endcase
		end else if (pick >= 97) begin
			acc.command = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		end
		// The lock can never be undone without a reset, so only the closing rows set it.
		if (acc.command == bsbd_pkg::CMD_IO_WRITE &&
				(acc.address & bsbd_pkg::BANK_PORT_MASK) == '0)
			acc.write_data[bsbd_pkg::BANK_LOCK_BIT] = 1'b0;
		return acc;
	endfunction

	task automatic send_access(input bus_access_t acc, input bit typed, input decode_t want);
		decode_t predicted;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= acc.command;
		address <= acc.address;
		write_data <= acc.write_data;
		key_rows <= acc.key_rows;
		tape_level <= acc.tape_level;
		disk_read_data <= acc.disk_read_data;
		disk_data_request <= acc.disk_data_request;
		disk_interrupt <= acc.disk_interrupt;
		do
			@(posedge clk);
		while (in_stall);
		predicted = decode_access(acc);
		expected_decodes.push_back(typed ? want : predicted);
	endtask

	task automatic run_rows(input stim_row_t rows[$]);
		foreach (rows[i])
			send_access(rows[i].access, rows[i].typed, rows[i].want);
	endtask

	task automatic wait_for_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_decodes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_decodes.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				head = expected_decodes.pop_front();
				compare_field("mem_is_rom", head.mem_is_rom, mem_is_rom);
				compare_field("mem_page", head.mem_page, mem_page);
				compare_field("mem_offset", head.mem_offset, mem_offset);
				compare_field("mem_write_enable", head.mem_write_enable, mem_write_enable);
				compare_field("io_data", head.io_data, io_data);
				compare_field("disk_write_strobe", head.disk_write_strobe, disk_write_strobe);
				compare_field("disk_read_strobe", head.disk_read_strobe, disk_read_strobe);
				compare_field("disk_register", head.disk_register, disk_register);
				compare_field("border_color", head.border_color, border_color);
				compare_field("beeper_level", head.beeper_level, beeper_level);
				compare_field("shadow_screen", head.shadow_screen, shadow_screen);
				compare_field("video_sync_request", head.video_sync_request,
					video_sync_request);
			end
		end
	end

	initial begin
		bank_reg = '0;
		disk_paged = 1'b0;
		rom_sel = '0;
		border_reg = '0;
		beeper_reg = 1'b0;

		opening_rows.push_back(typed_row(access_row(bsbd_pkg::CMD_FETCH, 16'h0000),
			mem_decode(1'b1, 3'd0, 14'h0000, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(typed_row(access_row(bsbd_pkg::CMD_MEM_READ, 16'hFFFF),
			mem_decode(1'b0, 3'd0, 14'h3FFF, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(typed_row(
			access_row(bsbd_pkg::CMD_MEM_WRITE, 16'h3FFF, 8'hFF),
			mem_decode(1'b1, 3'd0, 14'h3FFF, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(typed_row(
			access_row(bsbd_pkg::CMD_MEM_WRITE, 16'h4000, 8'h00),
			mem_decode(1'b0, 3'd5, 14'h0000, 1'b1, 1'b1, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(typed_row(
			access_row(bsbd_pkg::CMD_MEM_WRITE, 16'h5B00, 8'hA5),
			mem_decode(1'b0, 3'd5, 14'h1B00, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_MEM_WRITE, 16'h5AFF, 8'h5A));
		opening_rows.push_back(typed_row(
			access_row(bsbd_pkg::CMD_IO_READ, 16'h00FE, 8'h00, 64'h0, 1'b0),
			io_decode(8'h00, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(typed_row(
			access_row(bsbd_pkg::CMD_IO_READ, 16'hFFFE, 8'h00, '1, 1'b1),
			io_decode(8'hFF, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_IO_READ, 16'hFEFE, 8'h00,
			64'h5555_AAAA_3C3C_C31E, 1'b1));
		opening_rows.push_back(typed_row(access_row(bsbd_pkg::CMD_IO_READ, 16'h001F),
			io_decode(8'h00, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(typed_row(access_row(bsbd_pkg::CMD_IO_READ, 16'h00FF),
			io_decode(8'hFF, 1'b0, 3'd0, 1'b0, 1'b0)));
		opening_rows.push_back(typed_row(
			access_row(bsbd_pkg::CMD_IO_WRITE, 16'h00FE, 8'hFF),
			io_decode(8'hFF, 1'b1, 3'd7, 1'b1, 1'b0)));
		opening_rows.push_back(typed_row(
			access_row(bsbd_pkg::CMD_IO_WRITE, 16'h7FFD, 8'h18),
			io_decode(8'hFF, 1'b1, 3'd7, 1'b1, 1'b1)));
		// Fetch in the disk window pages the disk ROM in but is still translated via ROM 1.
		opening_rows.push_back(typed_row(access_row(bsbd_pkg::CMD_FETCH, 16'h3D00),
			mem_decode(1'b1, 3'd1, 14'h3D00, 1'b0, 1'b0, 3'd7, 1'b1, 1'b1)));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_FETCH, 16'h3FFF));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_IO_WRITE, 16'h007F, 8'h5A));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_IO_WRITE, 16'h00FF, 8'hC3));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_IO_READ, 16'h001F, 8'h00, '1,
			1'b0, 8'hA5));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_IO_READ, 16'h00FF, 8'h00, '1,
			1'b0, 8'h3C, 1'b1, 1'b1));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_IO_WRITE, 16'h7FFD, 8'h07));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_MEM_WRITE, 16'hC000, 8'h81));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_FETCH, 16'h8000));
		opening_rows.push_back(access_row(bsbd_pkg::CMD_MEM_READ, 16'h2000));
		opening_rows.push_back(access_row(CMD_SPARE_LO, 16'h1234, 8'h55));
		opening_rows.push_back(access_row(CMD_SPARE_HI, 16'hFFFF, 8'hFF));

		locked_rows.push_back(access_row(bsbd_pkg::CMD_IO_WRITE, 16'h7FFD, 8'h20));
		locked_rows.push_back(access_row(bsbd_pkg::CMD_IO_WRITE, 16'h7FFD, 8'h1F));
		locked_rows.push_back(access_row(bsbd_pkg::CMD_IO_WRITE, 16'h7FFC, 8'h12));
		locked_rows.push_back(access_row(bsbd_pkg::CMD_FETCH, 16'h3D00));
		locked_rows.push_back(access_row(bsbd_pkg::CMD_MEM_WRITE, 16'hFFFF, 8'hFF));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_rows(opening_rows);
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			if (n == 400)
				steady <= 1'b1;
			if (n == 600)
				steady <= 1'b0;
			if (n == 800)
				wait_for_results();
			send_access(random_access(), 1'b0, '0);
		end
		// Locking the bank register is final, so it is exercised last.
		wait_for_results();
		run_rows(locked_rows);
		wait_for_results();

		if (expected_decodes.size() != 0) begin
			$error("%0d requests never produced a result", expected_decodes.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
